@@ rtl/four_line_plate_reverb_core_defines.svh @@
// assertion macros for the plate reverb core
`ifndef FOUR_LINE_PLATE_REVERB_CORE_DEFINES_SVH
`define FOUR_LINE_PLATE_REVERB_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FLPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FLPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/flpr_pkg.sv @@
package flpr_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int INT_W     = SAMPLE_W + 4;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = COEF_W + 1;
    localparam int MA_W      = INT_W + 1;
    localparam int MB_W      = CFG_W + 1;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int DAMP_SH   = 16;
    localparam int FB_SH     = 16;
    localparam int WET_SH    = 17;
    localparam int NUM_LINES = 4;
    localparam int K_W       = $clog2(NUM_LINES);

    localparam int DEF_LINE0_LEN = 1063;
    localparam int DEF_LINE1_LEN = 1377;
    localparam int DEF_LINE2_LEN = 1709;
    localparam int DEF_LINE3_LEN = 2055;

    localparam logic [CFG_W-1:0]  COEF_ONE      = CFG_W'(65536);
    localparam logic [COEF_W-1:0] RST_FEEDBACK  = COEF_W'(39977);
    localparam logic [CFG_W-1:0]  RST_DAMP      = CFG_W'(31982);
    localparam logic [CFG_W-1:0]  RST_WET       = CFG_W'(32768);

    typedef enum logic [1:0] {
        CFG_FEEDBACK = 2'd0,
        CFG_DAMP     = 2'd1,
        CFG_WET      = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_DMUL,
        ST_DUPD,
        ST_FMUL,
        ST_WR,
        ST_WMUL,
        ST_WSUM
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_word;

    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W+1:0] v);
        logic [2:0] top;
        top = v[INT_W+1:INT_W-1];
        if ((&top) || !(|top)) begin
            return v[INT_W-1:0];
        end else if (v[INT_W+1]) begin
            return {1'b1, {(INT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(INT_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [INT_W:0] v);
        logic [INT_W-SAMPLE_W+1:0] top;
        top = v[INT_W:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            return v[SAMPLE_W-1:0];
        end else if (v[INT_W]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [CFG_W-1:0] clamp_coef(input logic [CFG_W-1:0] c);
        return (c > COEF_ONE) ? COEF_ONE : c;
    endfunction

endpackage

@@ rtl/flpr_mul.sv @@
module flpr_mul
    import flpr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MA_W-1:0]   i_a,
    input  logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/flpr_line_ram.sv @@
module flpr_line_ram
    import flpr_pkg::*;
#(
    parameter int DEPTH  = DEF_LINE0_LEN + DEF_LINE1_LEN + DEF_LINE2_LEN + DEF_LINE3_LEN,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_addr,
    input  logic signed [INT_W-1:0] i_wdata,
    output logic signed [INT_W-1:0] o_rdata
);

    logic signed [INT_W-1:0] r_mem [DEPTH];
    logic signed [INT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/four_line_plate_reverb_core.sv @@
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in_word  (t_in_word)
// out       output     o_out_valid / i_out_ready   o_out_word (t_out_word)
// cfg       input      i_cfg_wr_en                 i_cfg_index, i_cfg_wdata
//
// a word is taken in idle; then per line a read, a damping multiply and update;
// then per line feedback multiply and write-back; last the left and right wet mix
// all run in turn: a single shared multiplier and a single-port line ram
// no clearing pass: a line reads as zero until its write position first wraps
// a new word is taken while the previous result waits in the output register;
// a full output register holds the core in its last step

module four_line_plate_reverb_core
    import flpr_pkg::*;
#(
    parameter int LINE0_LEN = DEF_LINE0_LEN,
    parameter int LINE1_LEN = DEF_LINE1_LEN,
    parameter int LINE2_LEN = DEF_LINE2_LEN,
    parameter int LINE3_LEN = DEF_LINE3_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    `include "four_line_plate_reverb_core_defines.svh"

    localparam int TOTAL   = LINE0_LEN + LINE1_LEN + LINE2_LEN + LINE3_LEN;
    localparam int ADDR_W  = $clog2(TOTAL);
    localparam int MAX01   = (LINE0_LEN > LINE1_LEN) ? LINE0_LEN : LINE1_LEN;
    localparam int MAX23   = (LINE2_LEN > LINE3_LEN) ? LINE2_LEN : LINE3_LEN;
    localparam int MAX_LEN = (MAX01 > MAX23) ? MAX01 : MAX23;
    localparam int POS_W   = $clog2(MAX_LEN);

    localparam logic [ADDR_W-1:0] BASE0 = '0;
    localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(LINE0_LEN);
    localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(LINE0_LEN + LINE1_LEN);
    localparam logic [ADDR_W-1:0] BASE3 = ADDR_W'(LINE0_LEN + LINE1_LEN + LINE2_LEN);
    localparam logic [POS_W-1:0]  LAST0 = POS_W'(LINE0_LEN - 1);
    localparam logic [POS_W-1:0]  LAST1 = POS_W'(LINE1_LEN - 1);
    localparam logic [POS_W-1:0]  LAST2 = POS_W'(LINE2_LEN - 1);
    localparam logic [POS_W-1:0]  LAST3 = POS_W'(LINE3_LEN - 1);
    localparam logic [K_W-1:0]    K_LAST = K_W'(NUM_LINES - 1);

    t_state                  r_state, n_state;
    logic [K_W-1:0]          r_k, n_k;
    logic [COEF_W-1:0]       r_fb;
    logic [CFG_W-1:0]        r_alpha;
    logic [CFG_W-1:0]        r_wet;
    logic signed [SAMPLE_W-1:0] r_left, r_right, r_mono, r_left_out;
    logic [POS_W-1:0]        r_pos [NUM_LINES];
    logic [NUM_LINES-1:0]    r_full;
    logic signed [INT_W-1:0] r_damp [NUM_LINES];
    logic signed [INT_W-1:0] r_rd [NUM_LINES];
    t_out_word               r_out_word;
    logic                    r_out_valid;

    logic                    in_acc, out_free, out_load, wrap;
    logic [POS_W-1:0]        cur_pos, cur_last;
    logic [ADDR_W-1:0]       cur_base, ram_addr;
    logic                    ram_en, ram_we, mul_en;
    logic signed [INT_W-1:0] ram_q, rd_eff, wr_data, damp_new;
    logic signed [MA_W-1:0]  mul_a, diff, h_val, pair_sum;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod, damp_sh, fb_sh, wet_sh;
    logic signed [INT_W:0]   damp_step, fb_step, wet_step;
    logic signed [INT_W+1:0] h_sum;
    logic signed [SAMPLE_W:0] in_sum;
    logic signed [SAMPLE_W-1:0] dry, out_val;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = (r_state == ST_WSUM) && (r_k == K_W'(1)) && out_free;

    always_comb begin
        case (r_k)
            2'd0: begin
                cur_base = BASE0;
                cur_last = LAST0;
            end
            2'd1: begin
                cur_base = BASE1;
                cur_last = LAST1;
            end
            2'd2: begin
                cur_base = BASE2;
                cur_last = LAST2;
            end
            default: begin
                cur_base = BASE3;
                cur_last = LAST3;
            end
        endcase
    end

    assign cur_pos  = r_pos[r_k];
    assign wrap     = (cur_pos == cur_last);
    assign ram_addr = cur_base + ADDR_W'(cur_pos);
    assign rd_eff   = r_full[r_k] ? ram_q : '0;

    // half-scaled hadamard row for line k
    always_comb begin
        case (r_k)
            2'd0: h_sum = (INT_W+2)'(r_damp[0]) + (INT_W+2)'(r_damp[1])
                        + (INT_W+2)'(r_damp[2]) + (INT_W+2)'(r_damp[3]);
            2'd1: h_sum = (INT_W+2)'(r_damp[0]) - (INT_W+2)'(r_damp[1])
                        + (INT_W+2)'(r_damp[2]) - (INT_W+2)'(r_damp[3]);
            2'd2: h_sum = (INT_W+2)'(r_damp[0]) + (INT_W+2)'(r_damp[1])
                        - (INT_W+2)'(r_damp[2]) - (INT_W+2)'(r_damp[3]);
            default: h_sum = (INT_W+2)'(r_damp[0]) - (INT_W+2)'(r_damp[1])
                           - (INT_W+2)'(r_damp[2]) + (INT_W+2)'(r_damp[3]);
        endcase
    end

    assign h_val    = h_sum[INT_W+1:1];
    assign diff     = MA_W'(rd_eff) - MA_W'(r_damp[r_k]);
    assign pair_sum = r_k[0] ? (MA_W'(r_rd[1]) + MA_W'(r_rd[3]))
                             : (MA_W'(r_rd[0]) + MA_W'(r_rd[2]));

    assign damp_sh   = prod >>> DAMP_SH;
    assign fb_sh     = prod >>> FB_SH;
    assign wet_sh    = prod >>> WET_SH;
    assign damp_step = damp_sh[INT_W:0];
    assign fb_step   = fb_sh[INT_W:0];
    assign wet_step  = wet_sh[INT_W:0];
    assign damp_new  = sat_int((INT_W+2)'(r_damp[r_k]) + (INT_W+2)'(damp_step));
    assign wr_data   = sat_int((INT_W+2)'(r_mono) + (INT_W+2)'(fb_step));
    assign dry       = r_k[0] ? r_right : r_left;
    assign out_val   = sat_sample((INT_W+1)'(dry) + wet_step);
    assign in_sum    = (SAMPLE_W+1)'(i_in_word.left_in) + (SAMPLE_W+1)'(i_in_word.right_in);

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RD;
                    n_k     = '0;
                end
            end
            ST_RD: n_state = ST_DMUL;
            ST_DMUL: n_state = ST_DUPD;
            ST_DUPD: begin
                if (r_k == K_LAST) begin
                    n_state = ST_FMUL;
                    n_k     = '0;
                end else begin
                    n_state = ST_RD;
                    n_k     = r_k + K_W'(1);
                end
            end
            ST_FMUL: n_state = ST_WR;
            ST_WR: begin
                if (r_k == K_LAST) begin
                    n_state = ST_WMUL;
                    n_k     = '0;
                end else begin
                    n_state = ST_FMUL;
                    n_k     = r_k + K_W'(1);
                end
            end
            ST_WMUL: n_state = ST_WSUM;
            ST_WSUM: begin
                if (r_k == '0) begin
                    n_state = ST_WMUL;
                    n_k     = K_W'(1);
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_in_ready = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        mul_en     = 1'b0;
        mul_a      = diff;
        mul_b      = $signed({1'b0, clamp_coef(r_alpha)});
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RD: ram_en = 1'b1;
            ST_DMUL: mul_en = 1'b1;
            ST_FMUL: begin
                mul_en = 1'b1;
                mul_a  = h_val;
                mul_b  = $signed({2'b00, r_fb});
            end
            ST_WR: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            ST_WMUL: begin
                mul_en = 1'b1;
                mul_a  = pair_sum;
                mul_b  = $signed({1'b0, clamp_coef(r_wet)});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_fb        <= RST_FEEDBACK;
            r_alpha     <= RST_DAMP;
            r_wet       <= RST_WET;
            r_full      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++) begin
                r_pos[i]  <= '0;
                r_damp[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FEEDBACK: r_fb    <= i_cfg_wdata[COEF_W-1:0];
                    CFG_DAMP:     r_alpha <= i_cfg_wdata;
                    CFG_WET:      r_wet   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == ST_DUPD) begin
                r_damp[r_k] <= damp_new;
            end
            if (r_state == ST_WR) begin
                r_pos[r_k] <= wrap ? '0 : cur_pos + POS_W'(1);
                if (wrap) begin
                    r_full[r_k] <= 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left  <= i_in_word.left_in;
            r_right <= i_in_word.right_in;
            r_mono  <= in_sum[SAMPLE_W:1];
        end
        if (r_state == ST_DMUL) begin
            r_rd[r_k] <= rd_eff;
        end
        if ((r_state == ST_WSUM) && (r_k == '0)) begin
            r_left_out <= out_val;
        end
        if (out_load) begin
            r_out_word.left_out  <= r_left_out;
            r_out_word.right_out <= out_val;
        end
    end

    flpr_line_ram #(
        .DEPTH  (TOTAL),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (wr_data),
        .o_rdata (ram_q)
    );

    flpr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `FLPR_ASSERT_NEXT(a_start_line0, in_acc, (r_state == ST_RD) && (r_k == '0), "word accepted but line walk did not start at line 0")
    `FLPR_ASSERT_NOW(a_pos_range, 1'b1, cur_pos <= cur_last, "write position beyond its line")
    `FLPR_ASSERT_NEXT(a_full_sticky, 1'b1, (r_full & $past(r_full)) == $past(r_full), "line fill flag dropped")
    `FLPR_ASSERT_NEXT(a_result_shown, out_load, o_out_valid && (r_state == ST_IDLE), "finished word not presented")

endmodule
